// File: rtl/core/spq_pkg.sv
// Shared constants and codes for the stable priority queue.
`default_nettype none

package spq_pkg;

    // Default sizing of the queue.
    localparam int DEPTH_DEFAULT         = 16;
    localparam int PRIORITY_BITS_DEFAULT = 16;
    localparam int PAYLOAD_BITS_DEFAULT  = 32;

    // Width of the status field of a result word.
    localparam int STATUS_BITS = 2;

    // Operation carried by a request word.
    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    // Completion status of a result word.
    typedef enum logic [STATUS_BITS-1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

endpackage

`default_nettype wire

// File: rtl/core/spq_if.sv
// Request and result channel interfaces of the stable priority queue.
`default_nettype none

interface spq_req_if
    import spq_pkg::*;
#(
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEFAULT,
    parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEFAULT
);
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [PRIORITY_BITS-1:0] job_priority;
    logic [PAYLOAD_BITS-1:0]  job_payload;

    modport source (output valid, output op, output job_priority, output job_payload,
                    input ready);
    modport sink   (input valid, input op, input job_priority, input job_payload,
                    output ready);
endinterface

interface spq_rsp_if
    import spq_pkg::*;
#(
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEFAULT,
    parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEFAULT,
    parameter int COUNT_BITS    = $clog2(DEPTH_DEFAULT + 1)
);
    logic                     valid;
    logic                     ready;
    logic [STATUS_BITS-1:0]   status;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic [PAYLOAD_BITS-1:0]  out_payload;
    logic [COUNT_BITS-1:0]    fill_level;

    modport source (output valid, output status, output out_priority, output out_payload,
                    output fill_level, input ready);
    modport sink   (input valid, input status, input out_priority, input out_payload,
                    input fill_level, output ready);
endinterface

`default_nettype wire

// File: rtl/core/stable_priority_queue.sv
// Top level of the stable priority queue: request handling, cell chain and result register.
// The result word of a request is registered and valid in the cycle after it is accepted.
// Throughput: one request per cycle while the result register is empty or being drained
// in the same cycle; every push or pop updates all slots of the sorted cell chain together.
// Reset: rst_n clears the fill count, all slot valid bits and the result valid flag.
`default_nettype none

module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEFAULT,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEFAULT,
    parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic                     req_acc;
    logic                     is_pop;
    logic                     is_full;
    logic                     is_empty;
    logic                     push_en;
    logic                     pop_en;

    logic [COUNT_BITS-1:0]    count_reg;
    logic [COUNT_BITS-1:0]    count_next;

    logic                     res_valid_reg;
    logic                     res_valid_next;
    logic [STATUS_BITS-1:0]   status_reg;
    logic [STATUS_BITS-1:0]   status_next;
    logic [PRIORITY_BITS-1:0] res_prio_reg;
    logic [PRIORITY_BITS-1:0] res_prio_next;
    logic [PAYLOAD_BITS-1:0]  res_payload_reg;
    logic [PAYLOAD_BITS-1:0]  res_payload_next;
    logic [COUNT_BITS-1:0]    fill_reg;

    logic [DEPTH-1:0]         chain_valid;
    logic [DEPTH-1:0]         chain_keep;
    logic [PRIORITY_BITS-1:0] chain_prio    [DEPTH];
    logic [PAYLOAD_BITS-1:0]  chain_payload [DEPTH];

    // Request decode.
    assign req.ready = !res_valid_reg || rsp.ready;
    assign req_acc   = req.valid && req.ready;
    assign is_pop    = (req.op == OP_POP);
    assign is_full   = (count_reg == COUNT_BITS'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign push_en   = req_acc && !is_pop && !is_full;
    assign pop_en    = req_acc && is_pop && !is_empty;

    // Sorted chain of slots; slot zero always holds the best entry.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                     left_keep;
        logic                     left_valid;
        logic [PRIORITY_BITS-1:0] left_prio;
        logic [PAYLOAD_BITS-1:0]  left_payload;
        logic                     right_valid;
        logic [PRIORITY_BITS-1:0] right_prio;
        logic [PAYLOAD_BITS-1:0]  right_payload;

        if (i == 0)
        begin : g_head
            assign left_keep    = 1'b1;
            assign left_valid   = 1'b0;
            assign left_prio    = '0;
            assign left_payload = '0;
        end
        else
        begin : g_body
            assign left_keep    = chain_keep[i-1];
            assign left_valid   = chain_valid[i-1];
            assign left_prio    = chain_prio[i-1];
            assign left_payload = chain_payload[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_valid   = 1'b0;
            assign right_prio    = '0;
            assign right_payload = '0;
        end
        else
        begin : g_inner
            assign right_valid   = chain_valid[i+1];
            assign right_prio    = chain_prio[i+1];
            assign right_payload = chain_payload[i+1];
        end

        spq_cell
        #(
            .PRIORITY_BITS (PRIORITY_BITS),
            .PAYLOAD_BITS  (PAYLOAD_BITS)
        )
        u_cell
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .push_en       (push_en),
            .pop_en        (pop_en),
            .new_prio      (req.job_priority),
            .new_payload   (req.job_payload),
            .left_keep     (left_keep),
            .left_valid    (left_valid),
            .left_prio     (left_prio),
            .left_payload  (left_payload),
            .right_valid   (right_valid),
            .right_prio    (right_prio),
            .right_payload (right_payload),
            .keep          (chain_keep[i]),
            .valid         (chain_valid[i]),
            .prio          (chain_prio[i]),
            .payload       (chain_payload[i])
        );
    end

    // Fill count and result word for the accepted request.
    always_comb
    begin
        count_next       = count_reg;
        status_next      = STATUS_OK;
        res_prio_next    = '0;
        res_payload_next = '0;
        if (push_en)
        begin
            count_next = count_reg + COUNT_BITS'(1);
        end
        else if (pop_en)
        begin
            count_next       = count_reg - COUNT_BITS'(1);
            res_prio_next    = chain_prio[0];
            res_payload_next = chain_payload[0];
        end
        if (req_acc && !is_pop && is_full)
        begin
            status_next = STATUS_FULL;
        end
        else if (req_acc && is_pop && is_empty)
        begin
            status_next = STATUS_EMPTY;
        end
        res_valid_next = res_valid_reg;
        if (req_acc)
        begin
            res_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result word payload, loaded when a request is accepted.
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            status_reg      <= status_next;
            res_prio_reg    <= res_prio_next;
            res_payload_reg <= res_payload_next;
            fill_reg        <= count_next;
        end
    end

    assign rsp.valid        = res_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_priority = res_prio_reg;
    assign rsp.out_payload  = res_payload_reg;
    assign rsp.fill_level   = fill_reg;

`ifndef SYNTHESIS
    // The fill count always equals the number of occupied slots.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(chain_valid) == int'(count_reg))
        else $error("fill count differs from occupied slots");

    // Slot zero holds an entry no worse than slot one.
    a_head_best: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[1] |-> (chain_prio[0] >= chain_prio[1]))
        else $error("head slot is not the best entry");

    // A full status is only reported with a full queue.
    a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && status_reg == STATUS_FULL) |-> (fill_reg == COUNT_BITS'(DEPTH)))
        else $error("full status with room left");

    // A pop from a non-empty queue removes exactly one entry.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        pop_en |=> (count_reg == $past(count_reg) - COUNT_BITS'(1)))
        else $error("pop did not remove one entry");
`endif

endmodule

`default_nettype wire

// File: rtl/core/spq_cell.sv
// One slot of the sorted shift chain: holds an entry and trades it with its neighbors.
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEFAULT,
    parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEFAULT
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push_en,
    input  wire logic                     pop_en,
    input  wire logic [PRIORITY_BITS-1:0] new_prio,
    input  wire logic [PAYLOAD_BITS-1:0]  new_payload,
    input  wire logic                     left_keep,
    input  wire logic                     left_valid,
    input  wire logic [PRIORITY_BITS-1:0] left_prio,
    input  wire logic [PAYLOAD_BITS-1:0]  left_payload,
    input  wire logic                     right_valid,
    input  wire logic [PRIORITY_BITS-1:0] right_prio,
    input  wire logic [PAYLOAD_BITS-1:0]  right_payload,
    output logic                          keep,
    output logic                          valid,
    output logic [PRIORITY_BITS-1:0]      prio,
    output logic [PAYLOAD_BITS-1:0]       payload
);

    logic                     valid_reg;
    logic                     valid_next;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [PRIORITY_BITS-1:0] prio_next;
    logic [PAYLOAD_BITS-1:0]  payload_reg;
    logic [PAYLOAD_BITS-1:0]  payload_next;

    // An entry of equal or higher priority stays ahead of a new word, so ties keep
    // their arrival order.
    assign keep = valid_reg && (prio_reg >= new_prio);

    // On a push the first non-kept slot takes the new word and the slots behind it
    // shift one place back; on a pop every slot takes its right neighbor.
    always_comb
    begin
        valid_next   = valid_reg;
        prio_next    = prio_reg;
        payload_next = payload_reg;
        if (pop_en)
        begin
            valid_next   = right_valid;
            prio_next    = right_prio;
            payload_next = right_payload;
        end
        else if (push_en && !keep)
        begin
            if (left_keep)
            begin
                valid_next   = 1'b1;
                prio_next    = new_prio;
                payload_next = new_payload;
            end
            else
            begin
                valid_next   = left_valid;
                prio_next    = left_prio;
                payload_next = left_payload;
            end
        end
    end

    // Valid bit is control state and is cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry contents need no reset; they are read only while valid.
    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign valid   = valid_reg;
    assign prio    = prio_reg;
    assign payload = payload_reg;

endmodule

`default_nettype wire
